[src/aob_pkg.sv]
// ----------------------------------------------------------------------------
// aob_pkg: shared types and constants of the alpha over blender
// Pixel and result beat structs, the divider lane word and its widths.
// ----------------------------------------------------------------------------
package aob_pkg;

  localparam int CH_W      = 8;
  localparam int CH_MAX    = 255;
  localparam int NUM_LANES = 4;
  localparam int COL_LANES = 3;
  localparam int ALPHA_LANE = 3;
  localparam int Q_W       = 8;
  localparam int NUM_CELLS = Q_W;
  localparam int REM_W     = 25;
  localparam int DIV_W     = 17;
  localparam int ALPHA_DIV = 2 * CH_MAX;

  typedef struct packed {
    logic [CH_W-1:0] front_red;
    logic [CH_W-1:0] front_green;
    logic [CH_W-1:0] front_blue;
    logic [CH_W-1:0] front_alpha;
    logic [CH_W-1:0] back_red;
    logic [CH_W-1:0] back_green;
    logic [CH_W-1:0] back_blue;
    logic [CH_W-1:0] back_alpha;
  } aob_pix_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } aob_res_t;

  // lanes 0..2 colour (divisor div), lane 3 alpha (divisor ALPHA_DIV)
  typedef struct packed {
    logic [NUM_LANES-1:0][REM_W-1:0] rem;
    logic [DIV_W-1:0]                div;
    logic [NUM_LANES-1:0][Q_W-1:0]   quo;
  } aob_div_t;

endpackage

[src/aob_prep.sv]
// ----------------------------------------------------------------------------
// aob_prep: weight and numerator stages
// Two registered stages: alpha weights, then per-channel numerators and the
// dividend/divisor pairs for the divider chain.
// ----------------------------------------------------------------------------
module aob_prep import aob_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  aob_pix_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output aob_div_t out_data_o
);

  typedef struct packed {
    logic [15:0]                     w;
    logic [15:0]                     fa255;
    logic [COL_LANES-1:0][CH_W-1:0]  front;
    logic [COL_LANES-1:0][CH_W-1:0]  back;
  } aob_mul_t;

  logic     s1_valid_q, s2_valid_q;
  logic     s1_en, s2_en;
  aob_mul_t s1_d, s1_q;
  aob_div_t s2_d, s2_q;
  logic [16:0] s_sum;
  logic [23:0] num [COL_LANES];

  assign s2_en      = !s2_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  always_comb begin
    s1_d.w        = 16'(in_data_i.back_alpha) *
                    (16'(CH_MAX) - 16'(in_data_i.front_alpha));
    s1_d.fa255    = 16'(in_data_i.front_alpha) * 16'(CH_MAX);
    s1_d.front[0] = in_data_i.front_red;
    s1_d.front[1] = in_data_i.front_green;
    s1_d.front[2] = in_data_i.front_blue;
    s1_d.back[0]  = in_data_i.back_red;
    s1_d.back[1]  = in_data_i.back_green;
    s1_d.back[2]  = in_data_i.back_blue;
  end

  assign s_sum = {1'b0, s1_q.w} + {1'b0, s1_q.fa255};

  always_comb begin
    for (int l = 0; l < COL_LANES; l++) begin
      num[l] = 24'(s1_q.back[l]) * 24'(s1_q.w) + 24'(s1_q.front[l]) * 24'(s1_q.fa255);
    end
  end

  always_comb begin
    s2_d = '0;
    for (int l = 0; l < COL_LANES; l++) begin
      s2_d.rem[l] = {num[l], 1'b0} + REM_W'(s_sum);
    end
    s2_d.rem[ALPHA_LANE] = REM_W'({s_sum, 1'b0}) + REM_W'(CH_MAX);
    // fully transparent pair: all-ones divisor against a zero dividend gives 0
    s2_d.div = (s_sum == '0) ? '1 : {s_sum[DIV_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) s1_q <= s1_d;
    if (s2_en && s1_valid_q) s2_q <= s2_d;
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

endmodule

[src/aob_div_cell.sv]
// ----------------------------------------------------------------------------
// aob_div_cell: one restoring division cell
// Resolves one quotient bit for every lane and hands the partial remainder on.
// ----------------------------------------------------------------------------
module aob_div_cell import aob_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  aob_div_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output aob_div_t out_data_o
);

  logic                 valid_q;
  logic                 en;
  aob_div_t             data_d, data_q;
  logic [REM_W-1:0]     sh [NUM_LANES];
  logic [NUM_LANES-1:0] ge;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    if (l == ALPHA_LANE) begin : g_alpha
      assign sh[l] = REM_W'(ALPHA_DIV) << BIT;
    end else begin : g_col
      assign sh[l] = REM_W'(in_data_i.div) << BIT;
    end
    assign ge[l] = in_data_i.rem[l] >= sh[l];
  end

  always_comb begin
    data_d = in_data_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (ge[l]) data_d.rem[l] = in_data_i.rem[l] - sh[l];
      data_d.quo[l] = {in_data_i.quo[l][Q_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[src/alpha_over_blend_top.sv]
// ----------------------------------------------------------------------------
// alpha_over_blend_top: straight-alpha "over" compositor
// Front pixel over back pixel, rounded to nearest, one pixel beat per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one pixel beat every cycle unless stalled and returns one result beat
// per pixel, in order, through two multiply stages and a chain of eight division
// cells, each resolving one quotient bit of all four channels; the last cell
// is the output register. Every stage stalls on its own, so gaps in the
// stream close up while a result waits and input stays open until every
// stage is full. A fully transparent pair gives an all-zero result.
module alpha_over_blend_top import aob_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  aob_pix_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output aob_res_t out_data_o
);

  logic     c_valid [NUM_CELLS+1];
  logic     c_ready [NUM_CELLS+1];
  aob_div_t c_data  [NUM_CELLS+1];

  aob_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (c_valid[0]),
    .out_ready_i (c_ready[0]),
    .out_data_o  (c_data[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    aob_div_cell #(
      .BIT (NUM_CELLS - 1 - k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c_valid[k]),
      .in_ready_o  (c_ready[k]),
      .in_data_i   (c_data[k]),
      .out_valid_o (c_valid[k+1]),
      .out_ready_i (c_ready[k+1]),
      .out_data_o  (c_data[k+1])
    );
  end

  assign c_ready[NUM_CELLS] = out_ready_i;
  assign out_valid_o        = c_valid[NUM_CELLS];

  assign out_data_o.out_red   = c_data[NUM_CELLS].quo[0];
  assign out_data_o.out_green = c_data[NUM_CELLS].quo[1];
  assign out_data_o.out_blue  = c_data[NUM_CELLS].quo[2];
  assign out_data_o.out_alpha = c_data[NUM_CELLS].quo[ALPHA_LANE];

  // input only blocks when the whole pipe is full behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output side free");

  // divisor handed to the chain is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[0] |-> (c_data[0].div != '0))
    else $error("zero divisor entered division chain");

  // final remainders below their divisors: quotient fully resolved
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (c_data[NUM_CELLS].rem[0] < REM_W'(c_data[NUM_CELLS].div) &&
                     c_data[NUM_CELLS].rem[1] < REM_W'(c_data[NUM_CELLS].div) &&
                     c_data[NUM_CELLS].rem[2] < REM_W'(c_data[NUM_CELLS].div) &&
                     c_data[NUM_CELLS].rem[ALPHA_LANE] < REM_W'(ALPHA_DIV)))
    else $error("division remainder out of range");

endmodule
